### rtl/dres_pkg.sv
// Shared types, widths and the date comparison for the date record sorter.
package dres_pkg;

  localparam int DRES_CAPACITY = 64;
  localparam int YEAR_W        = 16;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int TAG_W         = 16;
  localparam int REC_W         = YEAR_W + MONTH_W + DAY_W + TAG_W;
  localparam int TDATA_W       = ((REC_W + 7) / 8) * 8;

  // Declared from the top bit down so that the year sits in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } rec_t;

  // One word handed from the sequencer to the output stage.
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
    rec_t rec;
  } emit_t;

  // True when record a's date is strictly later than record b's date.
  function automatic logic date_later(input rec_t a, input rec_t b);
    return {a.year, a.month, a.day} > {b.year, b.month, b.day};
  endfunction

endpackage

### rtl/dres_core.sv
// Record memory and the load, sort and emit sequencer.
module dres_core #(
  parameter int CAPACITY = dres_pkg::DRES_CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dres_pkg::rec_t in_rec,
  input  logic           in_last,
  input  logic           out_free,
  output dres_pkg::emit_t emit
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_LOADI = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_WB    = 7'b0010000,
    ST_EREAD = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  dres_pkg::rec_t mem [CAPACITY];
  dres_pkg::rec_t rd_data_r;
  dres_pkg::rec_t hold_r, hold_nxt;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            dropped_r, dropped_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   k_r, k_nxt;

  logic            we;
  logic [AW-1:0]   wa;
  dres_pkg::rec_t  wd;
  logic            re;
  logic [AW-1:0]   ra;
  logic [CW-1:0]   last_idx;

  assign last_idx = count_r - CW'(1);
  assign in_ready = (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    hold_nxt    = hold_r;
    we          = 1'b0;
    wa          = '0;
    wd          = in_rec;
    re          = 1'b0;
    ra          = '0;
    emit        = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CW'(CAPACITY)) begin
            we        = 1'b1;
            wa        = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        i_nxt = '0;
        k_nxt = '0;
        if (count_r < CW'(2)) begin
          state_nxt = ST_EREAD;
        end else begin
          re        = 1'b1;
          ra        = '0;
          state_nxt = ST_LOADI;
        end
      end
      ST_LOADI: begin
        // The candidate for entry i is held in a register for the whole pass.
        hold_nxt  = rd_data_r;
        j_nxt     = i_r + AW'(1);
        re        = 1'b1;
        ra        = i_r + AW'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (dres_pkg::date_later(hold_r, rd_data_r)) begin
          we       = 1'b1;
          wa       = j_r;
          wd       = hold_r;
          hold_nxt = rd_data_r;
        end
        if (CW'(j_r) == last_idx) begin
          state_nxt = ST_WB;
        end else begin
          re    = 1'b1;
          ra    = j_r + AW'(1);
          j_nxt = j_r + AW'(1);
        end
      end
      ST_WB: begin
        we = 1'b1;
        wa = i_r;
        wd = hold_r;
        if (CW'(i_r) + CW'(2) < count_r) begin
          re        = 1'b1;
          ra        = i_r + AW'(1);
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_LOADI;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EREAD;
        end
      end
      ST_EREAD: begin
        re        = 1'b1;
        ra        = k_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.rec   = rd_data_r;
          emit.last  = (CW'(k_r) == last_idx);
          emit.ovf   = dropped_r;
          if (CW'(k_r) == last_idx) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_EREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

### rtl/dres_out.sv
// Output register stage that holds one result word until it is taken.
module dres_out (
  input  logic            clk,
  input  logic            rst_n,
  input  dres_pkg::emit_t emit,
  output logic            out_free,
  output logic            out_valid,
  input  logic            out_ready,
  output dres_pkg::rec_t  out_rec,
  output logic            out_last,
  output logic            out_ovf
);

  logic           valid_r;
  dres_pkg::rec_t rec_r;
  logic           last_r;
  logic           ovf_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rec   = rec_r;
  assign out_last  = last_r;
  assign out_ovf   = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      rec_r  <= emit.rec;
      last_r <= emit.last;
      ovf_r  <= emit.ovf;
    end
  end

endmodule

### rtl/date_record_exchange_sort_top.sv
// Top level of the date record sorter.
// Records are loaded one word per cycle until a word with in_tlast arrives; words beyond
// CAPACITY are dropped and the run's words then carry out_tuser high. The stored run is
// sorted in ascending date order (year, then month, then day) by an exchange sort, then
// emitted with out_tlast on its final word, and loading resumes. All records live in one
// memory with one write and one registered read port, so the sort makes one compare per
// cycle; each sorted word is then read from memory and handed to the output register,
// once it has room, before the next is read. Input is held off from the last loaded word
// until the final sorted word sits in the output register.
module date_record_exchange_sort_top #(
  parameter int CAPACITY = dres_pkg::DRES_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dres_pkg::TDATA_W-1:0] in_tdata,  // year, month, day, tag
  input  logic                         in_tlast,  // last_item
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dres_pkg::TDATA_W-1:0] out_tdata, // out_year, out_month, out_day, out_tag
  output logic                         out_tlast, // out_last
  output logic                         out_tuser  // overflow
);

  dres_pkg::rec_t  in_rec;
  dres_pkg::rec_t  out_rec;
  dres_pkg::emit_t emit;
  logic            out_free;

  assign in_rec    = dres_pkg::rec_t'(in_tdata[dres_pkg::REC_W-1:0]);
  assign out_tdata = dres_pkg::TDATA_W'(out_rec);

  dres_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_rec   (in_rec),
    .in_last  (in_tlast),
    .out_free (out_free),
    .emit     (emit)
  );

  dres_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

endmodule

### rtl/dres_checker.sv
// Port-level assertions for the date record sorter and their binding to the top level.
module dres_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         in_tlast,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [dres_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tlast,
  input logic                         out_tuser
);

  // A stalled word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word withdrawn while stalled");

  // A stalled word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast) &&
      $stable(out_tuser))
    else $error("output word changed while stalled");

  // The word that closes a set starts the sort, so loading stops at once.
  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken after the last word of a set");

  // Loading resumes only once the final word of the sorted run has been produced.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open while a sorted run is still being emitted");

endmodule

bind date_record_exchange_sort_top dres_checker u_dres_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### tb/sv/date_record_exchange_sort_top_tb.sv
// Self-checking testbench for the date record sorter top level.
module date_record_exchange_sort_top_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_WORDS    = 15;

  typedef enum int {
    DATES_FULL,
    DATES_CLUSTERED,
    DATES_EXTREME
  } date_mode_t;

  // One sorted word as it should leave the block.
  typedef struct {
    dres_pkg::rec_t rec;
    logic           last;
    logic           ovf;
  } sorted_word_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [dres_pkg::TDATA_W-1:0] in_tdata   = '0;
  logic                         in_tlast   = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [dres_pkg::TDATA_W-1:0] out_tdata;
  logic                         out_tlast;
  logic                         out_tuser;

  sorted_word_t   sorted_q[$];
  dres_pkg::rec_t load_buf[$];
  bit             load_dropped = 1'b0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int err_count    = 0;
  int words_in     = 0;
  int words_out    = 0;
  int runs_done    = 0;
  int ovf_runs     = 0;
  int idle_count   = 0;

  date_record_exchange_sort_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),  // year, month, day, tag
    .in_tlast   (in_tlast),  // last_item
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata), // out_year, out_month, out_day, out_tag
    .out_tlast  (out_tlast), // out_last
    .out_tuser  (out_tuser)  // overflow
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit date_is_later(dres_pkg::rec_t a, dres_pkg::rec_t b);
    if (a.year != b.year) return a.year > b.year;
    if (a.month != b.month) return a.month > b.month;
    return a.day > b.day;
  endfunction

  // Mirrors the block for one accepted word; a last word releases the sorted run.
  function automatic void predict_word(dres_pkg::rec_t rec, logic last);
    dres_pkg::rec_t run[$];
    dres_pkg::rec_t tmp;
    sorted_word_t   w;
    if (load_buf.size() < dres_pkg::DRES_CAPACITY) load_buf.push_back(rec);
    else load_dropped = 1'b1;
    if (last) begin
      run = load_buf;
      for (int i = 0; i < run.size(); i++) begin
        for (int j = i + 1; j < run.size(); j++) begin
          if (date_is_later(run[i], run[j])) begin
            tmp    = run[i];
            run[i] = run[j];
            run[j] = tmp;
          end
        end
      end
      for (int k = 0; k < run.size(); k++) begin
        w.rec  = run[k];
        w.last = (k == run.size() - 1);
        w.ovf  = load_dropped;
        sorted_q.push_back(w);
      end
      runs_done++;
      if (load_dropped) ovf_runs++;
      load_buf.delete();
      load_dropped = 1'b0;
    end
  endfunction

  function automatic dres_pkg::rec_t make_rec(int unsigned y, int unsigned m, int unsigned d,
                                              int unsigned t);
    dres_pkg::rec_t r;
    r.year  = y[dres_pkg::YEAR_W-1:0];
    r.month = m[dres_pkg::MONTH_W-1:0];
    r.day   = d[dres_pkg::DAY_W-1:0];
    r.tag   = t[dres_pkg::TAG_W-1:0];
    return r;
  endfunction

  function automatic dres_pkg::rec_t rand_rec(date_mode_t mode);
    case (mode)
      DATES_CLUSTERED: begin
        return make_rec($urandom_range(2003, 2000), $urandom_range(2), $urandom_range(3),
                        $urandom_range(16'hFFFF));
      end
      DATES_EXTREME: begin
        return make_rec($urandom_range(1) ? 16'hFFFF : 0, $urandom_range(1) ? 15 : 0,
                        $urandom_range(1) ? 31 : 0, $urandom_range(16'hFFFF));
      end
      default: begin
        return make_rec($urandom_range(16'hFFFF), $urandom_range(15), $urandom_range(31),
                        $urandom_range(16'hFFFF));
      end
    endcase
  endfunction

  // Offers one word, with random idle cycles first, and returns once it is taken.
  task automatic send_word(dres_pkg::rec_t rec, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(dres_pkg::TDATA_W - dres_pkg::REC_W){1'b0}}, rec};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_in++;
    predict_word(rec, last);
  endtask

  task automatic send_run(int n, date_mode_t mode);
    for (int k = 1; k <= n; k++) send_word(rand_rec(mode), k == n);
  endtask

  // Receiver stalls are redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    sorted_word_t   w;
    dres_pkg::rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      got = out_tdata[dres_pkg::REC_W-1:0];
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %0h", $time, out_tdata);
        err_count++;
      end else begin
        w = sorted_q.pop_front();
        check_field("year", w.rec.year, got.year);
        check_field("month", w.rec.month, got.month);
        check_field("day", w.rec.day, got.day);
        check_field("tag", w.rec.tag, got.tag);
        check_field("last", w.last, out_tlast);
        check_field("overflow", w.ovf, out_tuser);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[date_record_exchange_sort_top] ERROR");
      $finish;
    end
  end

  // Extreme field values and a midpoint date, in an order in which every one must move.
  task automatic test_corner_dates();
    send_word(make_rec(16'hFFFF, 15, 31, 16'hFFFF), 1'b0);
    send_word(make_rec(16'hFFFF, 15, 0, 16'h0000), 1'b0);
    send_word(make_rec(16'hFFFF, 0, 31, 16'hA5A5), 1'b0);
    send_word(make_rec(16'h0000, 15, 31, 16'h5A5A), 1'b0);
    send_word(make_rec(16'h8000, 8, 16, 16'h00FF), 1'b0);
    send_word(make_rec(16'h0000, 0, 0, 16'hFF00), 1'b1);
  endtask

  task automatic test_single_record();
    send_word(make_rec(16'h1234, 6, 15, 16'hBEEF), 1'b1);
    send_word(make_rec(16'h0000, 0, 0, 16'h0000), 1'b1);
  endtask

  // Equal dates with distinct tags expose the tie order left by the swaps.
  task automatic test_equal_dates();
    for (int k = 0; k < 8; k++)
      send_word(make_rec(2024 - (k % 2), 3, 7, k), 1'b0);
    for (int k = 0; k < 7; k++)
      send_word(make_rec(2023, 3, 7 + (k % 2), 16'h100 + k), k == 6);
  endtask

  // The last word exactly fills the store.
  task automatic test_full_store();
    send_run(dres_pkg::DRES_CAPACITY, DATES_CLUSTERED);
  endtask

  // Two extra words are dropped, then a run whose last word itself is dropped.
  task automatic test_overflow_drop();
    send_run(dres_pkg::DRES_CAPACITY + 2, DATES_FULL);
    send_run(dres_pkg::DRES_CAPACITY + 1, DATES_EXTREME);
  endtask

  task automatic test_random_runs(int src_pct, int snk_pct);
    int         start;
    int         n;
    int         pick;
    date_mode_t mode;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start        = words_in;
    while (words_in - start < PHASE_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 85) n = $urandom_range(12, 1);
      else if (pick < 97) n = $urandom_range(40, 13);
      else n = $urandom_range(dres_pkg::DRES_CAPACITY + 4, dres_pkg::DRES_CAPACITY - 2);
      pick = $urandom_range(99);
      mode = (pick < 45) ? DATES_FULL : (pick < 85) ? DATES_CLUSTERED : DATES_EXTREME;
      send_run(n, mode);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_dates();
    test_single_record();
    test_equal_dates();
    test_full_store();
    test_overflow_drop();
    test_random_runs(0, 0);
    test_random_runs(57, 0);
    test_random_runs(0, 57);
    test_random_runs(20, 20);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (load_buf.size() != 0) begin
      $display("%0t: %0d words still loading, expected 0", $time, load_buf.size());
      err_count++;
    end
    $display("Sent %0d words in %0d runs, %0d of them over capacity; checked %0d sorted words.",
             words_in, runs_done, ovf_runs, words_out);
    $display("Idle and stall phases covered, %0d mismatches found.", err_count);
    if (err_count == 0) begin
      $display("[date_record_exchange_sort_top] OK");
    end else begin
      $display("[date_record_exchange_sort_top] ERROR");
    end
    $finish;
  end

endmodule
